### rtl/takf_pkg.sv
// Shared types, constants and helpers for the tilt-angle Kalman filter.
// No dependencies.
`timescale 1ns / 1ps
package takf_pkg;

  localparam int DT_FRAC_BITS  = 24;
  localparam int COV_FRAC_BITS = 22;
  localparam int DIV_STEPS     = 64;

  localparam logic [1:0] REG_ANGLE_Q = 2'd0;
  localparam logic [1:0] REG_BIAS_Q  = 2'd1;
  localparam logic [1:0] REG_MEAS_R  = 2'd2;
  localparam logic [1:0] REG_DT      = 2'd3;

  localparam logic [30:0] ANGLE_Q_RESET = 31'd83886080;
  localparam logic [30:0] BIAS_Q_RESET  = 31'd83886080;
  localparam logic [30:0] MEAS_R_RESET  = 31'd1677722;
  localparam logic [23:0] DT_RESET      = 24'd30199;
  localparam logic signed [31:0] COV_ONE = 32'sd4194304;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  // Datapath operation codes, one per sequencer step.
  localparam logic [4:0] OP_RATE   = 5'd0;
  localparam logic [4:0] OP_ANG_P  = 5'd1;
  localparam logic [4:0] OP_D0     = 5'd2;
  localparam logic [4:0] OP_P00    = 5'd3;
  localparam logic [4:0] OP_P01    = 5'd4;
  localparam logic [4:0] OP_P11    = 5'd5;
  localparam logic [4:0] OP_ERR    = 5'd6;
  localparam logic [4:0] OP_DIV0   = 5'd7;
  localparam logic [4:0] OP_K0     = 5'd8;
  localparam logic [4:0] OP_DIV1   = 5'd9;
  localparam logic [4:0] OP_K1     = 5'd10;
  localparam logic [4:0] OP_C00    = 5'd11;
  localparam logic [4:0] OP_C01    = 5'd12;
  localparam logic [4:0] OP_C10    = 5'd13;
  localparam logic [4:0] OP_C11    = 5'd14;
  localparam logic [4:0] OP_ANG_U  = 5'd15;
  localparam logic [4:0] OP_BIAS_U = 5'd16;
  localparam logic [4:0] OP_OUT    = 5'd17;
  localparam logic [4:0] OP_NONE   = 5'd18;

  typedef struct packed {
    logic       start;
    logic [4:0] op;
    logic       mul_go;
    logic       div_go;
  } takf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } takf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(S32_MAX)) return S32_MAX;
    else if (v < 66'(S32_MIN)) return S32_MIN;
    else return v[31:0];
  endfunction

endpackage

### rtl/takf_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit magnitude.
// Depends on takf_pkg.
`timescale 1ns / 1ps
module takf_div import takf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic signed [63:0] num,
  input  logic        [32:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  logic [63:0] q;
  logic [33:0] rem;
  logic [6:0]  cnt;
  logic        neg;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem[32:0], q[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        rem  <= '0;
        neg  <= num[63];
        q    <= num[63] ? 64'(-num) : num;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial;
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[32:0], q[63]};
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Truncate toward zero, then saturate.
  always_comb begin
    logic signed [65:0] sq;
    sq  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    quo = sat32(sq);
  end
endmodule

### rtl/takf_datapath.sv
// Filter state, shared multiplier and divider, step operations.
// Depends on takf_pkg and takf_div.
`timescale 1ns / 1ps
module takf_datapath import takf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  takf_cmd_t          cmd,
  output takf_sts_t          sts,
  input  logic signed [31:0] meas_in,
  input  logic signed [31:0] gyro_in,
  input  logic        [30:0] angle_q,
  input  logic        [30:0] bias_q,
  input  logic        [30:0] meas_r,
  input  logic        [23:0] dt,
  output logic signed [31:0] angle_out,
  output logic signed [31:0] rate_out
);
  logic signed [31:0] angle, bias, p00, p01, p10, p11;
  logic signed [31:0] meas, gyro, rate, err, k0, k1, t0, t1;
  logic signed [33:0] d0;
  logic signed [33:0] ma;
  logic signed [32:0] mb;
  logic signed [66:0] prod;
  logic               mul_done;
  logic               dv_done;
  logic signed [31:0] dv_q;
  logic signed [63:0] dv_num;
  logic        [32:0] dv_den;
  logic signed [32:0] e;
  logic [5:0]         sh;

  assign e = 33'($signed({2'b0, meas_r})) + 33'(p00);
  assign sts.mul_done = mul_done;
  assign sts.div_done = dv_done;

  // Operand selection for the multiply of each step.
  always_comb begin
    ma = '0;
    mb = $signed({9'd0, dt});
    sh = 6'(DT_FRAC_BITS);
    case (cmd.op)
      OP_ANG_P: ma = 34'(rate);
      OP_P00:   ma = d0;
      OP_P01:   ma = -34'(p11);
      OP_P11:   ma = $signed({3'b0, bias_q});
      OP_C00: begin ma = 34'(k0); mb = 33'(t0); sh = 6'(COV_FRAC_BITS); end
      OP_C01: begin ma = 34'(k0); mb = 33'(t1); sh = 6'(COV_FRAC_BITS); end
      OP_C10: begin ma = 34'(k1); mb = 33'(t0); sh = 6'(COV_FRAC_BITS); end
      OP_C11: begin ma = 34'(k1); mb = 33'(t1); sh = 6'(COV_FRAC_BITS); end
      OP_ANG_U: begin ma = 34'(k0); mb = 33'(err); sh = 6'(COV_FRAC_BITS); end
      OP_BIAS_U: begin ma = 34'(k1); mb = 33'(err); sh = 6'(COV_FRAC_BITS); end
      default: ;
    endcase
  end

  always_comb begin
    dv_num = (cmd.op == OP_DIV1) ? 64'(p10) <<< COV_FRAC_BITS
                                 : 64'(p00) <<< COV_FRAC_BITS;
    dv_den = e[32:0];
  end

  takf_div u_div (
    .clk (clk), .rst (rst), .go (cmd.div_go),
    .num (dv_num), .den (dv_den), .done (dv_done), .quo (dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_done <= 1'b0;
      angle <= '0;
      bias  <= '0;
      p00   <= COV_ONE;
      p01   <= '0;
      p10   <= '0;
      p11   <= COV_ONE;
    end else begin
      mul_done <= cmd.mul_go;
      if (cmd.mul_go) prod <= 67'(ma * mb) >>> sh;
      if (cmd.start) begin
        meas <= meas_in;
        gyro <= gyro_in;
      end
      // apply a multiply step only once its product is ready
      if (!cmd.mul_go) begin
        case (cmd.op)
          OP_RATE:  rate <= sat32(66'(gyro) - 66'(bias));
          OP_ANG_P: angle <= sat32(66'(angle) + 66'(prod));
          OP_D0:    d0 <= 34'($signed({3'b0, angle_q})) - 34'(p01) - 34'(p10);
          OP_P00:   p00 <= sat32(66'(p00) + 66'(prod));
          OP_P01: begin
            p01 <= sat32(66'(p01) + 66'(prod));
            p10 <= sat32(66'(p10) + 66'(prod));
          end
          OP_P11:   p11 <= sat32(66'(p11) + 66'(prod));
          OP_ERR: begin
            err <= sat32(66'(meas) - 66'(angle));
            t0  <= p00;
            t1  <= p01;
          end
          OP_K0:    k0 <= (e > 0) ? dv_q : '0;
          OP_K1:    k1 <= (e > 0) ? dv_q : '0;
          OP_C00:   p00 <= sat32(66'(p00) - 66'(prod));
          OP_C01:   p01 <= sat32(66'(p01) - 66'(prod));
          OP_C10:   p10 <= sat32(66'(p10) - 66'(prod));
          OP_C11:   p11 <= sat32(66'(p11) - 66'(prod));
          OP_ANG_U: angle <= sat32(66'(angle) + 66'(prod));
          OP_BIAS_U: bias <= sat32(66'(bias) + 66'(prod));
          OP_OUT: begin
            angle_out <= angle;
            rate_out  <= sat32(66'(gyro) - 66'(bias));
          end
          default: ;
        endcase
      end
    end
  end
endmodule

### rtl/takf_ctrl.sv
// Step sequencer: issues multiply and divide commands for one word.
// Depends on takf_pkg.
`timescale 1ns / 1ps
module takf_ctrl import takf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_fire,
  input  takf_sts_t sts,
  output takf_cmd_t cmd,
  output logic      in_ready,
  output logic      out_valid
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state;
  logic [4:0] step;
  logic       needs_mul, needs_div, wait_done, out_load;

  always_comb begin
    needs_mul = (step == OP_ANG_P) || (step == OP_P00) || (step == OP_P01) ||
                (step == OP_P11) || (step == OP_C00) || (step == OP_C01) ||
                (step == OP_C10) || (step == OP_C11) || (step == OP_ANG_U) ||
                (step == OP_BIAS_U);
    needs_div = (step == OP_DIV0) || (step == OP_DIV1);
    wait_done = needs_div ? sts.div_done : sts.mul_done;
    out_load  = (state == S_ISSUE) && (step == OP_OUT) && !out_valid;
  end

  assign in_ready = (state == S_IDLE);

  // The op is shown while a unit starts too, so the datapath can pick its operands.
  always_comb begin
    cmd.start  = in_fire;
    cmd.mul_go = (state == S_ISSUE) && needs_mul;
    cmd.div_go = (state == S_ISSUE) && needs_div;
    cmd.op     = OP_NONE;
    if (state == S_ISSUE && !(step == OP_OUT && out_valid)) cmd.op = step;
    if (state == S_WAIT && wait_done && needs_mul) cmd.op = step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= OP_RATE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !out_fire);
      case (state)
        S_IDLE: if (in_fire) begin
          state <= S_ISSUE;
          step  <= OP_RATE;
        end
        S_ISSUE: begin
          if (needs_mul || needs_div) state <= S_WAIT;
          else if (step == OP_OUT) begin
            // hold the last step until the previous word has left
            if (out_load) state <= S_IDLE;
          end else step <= step + 5'd1;
        end
        S_WAIT: if (wait_done) begin
          state <= S_ISSUE;
          step  <= step + 5'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/tilt_angle_kalman_filter.sv
// Tilt-angle Kalman filter: angle and gyro bias with 2x2 covariance.
// Each word runs ten multiplies, two divides on one shared divider, and six
// steps that use neither unit. A new word is taken only once the sequencer is idle;
// a result waits in the output register while the next word is taken, and the
// last step holds until that result has left.
// Synchronous reset: angle and bias zero, covariance identity, registers to defaults.
`timescale 1ns / 1ps
module tilt_angle_kalman_filter import takf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured_angle, [63:32] gyro_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [31:0] angle_estimate, [63:32] corrected_rate
);
  logic [30:0] angle_q, bias_q, meas_r;
  logic [23:0] dt;
  takf_cmd_t cmd;
  takf_sts_t sts;
  logic signed [31:0] angle_out, rate_out;
  logic in_fire, out_fire;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata  = {rate_out, angle_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_q <= ANGLE_Q_RESET;
      bias_q  <= BIAS_Q_RESET;
      meas_r  <= MEAS_R_RESET;
      dt      <= DT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE_Q: angle_q <= cfg_data;
        REG_BIAS_Q:  bias_q  <= cfg_data;
        REG_MEAS_R:  meas_r  <= cfg_data;
        REG_DT:      dt      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  takf_ctrl u_ctrl (
    .clk (clk), .rst (rst), .in_fire (in_fire), .out_fire (out_fire),
    .sts (sts), .cmd (cmd), .in_ready (s_tready), .out_valid (m_tvalid)
  );

  takf_datapath u_dp (
    .clk (clk), .rst (rst), .cmd (cmd), .sts (sts),
    .meas_in (s_tdata[31:0]), .gyro_in (s_tdata[63:32]),
    .angle_q (angle_q), .bias_q (bias_q), .meas_r (meas_r), .dt (dt),
    .angle_out (angle_out), .rate_out (rate_out)
  );

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed");
  a_one_go: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_go && cmd.div_go)) else $error("two units started");
endmodule
